// ===== src/pai_pkg.sv =====
// ----------------------------------------------------------------------------
// pai_pkg
// shared types and constants of the positional array with insert and delete
// ----------------------------------------------------------------------------
package pai_pkg;

  localparam int CapacityDef = 64;
  localparam int DataW       = 32;
  localparam int PosW        = 7;
  localparam int CountW      = 7;
  localparam int IndexW      = 6;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_e                    cmd;
    logic [PosW-1:0]         pos;
    logic [CountW-1:0]       cnt;
    logic signed [DataW-1:0] val;
  } pai_ctrl_t;

endpackage

// ===== src/positional_array_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_array_insert_delete
// ordered list of signed elements kept in a chain of shifting cells
// ----------------------------------------------------------------------------
// insert, delete, unused code: one result in the cycle after accept, one item per cycle
// nonempty traverse: results from the head cell, one per cycle; busy in the S_TRAV state
//   while the cell chain rotates one place per cycle past the head cell
// reset clears the count and control state; the cells themselves are not cleared,
//   only entries below the count are ever emitted
// results cannot be stalled by the receiver
module positional_array_insert_delete import pai_pkg::*; #(
  parameter int CAPACITY = CapacityDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               operation_i,
  input  logic [PosW-1:0]          position_i,
  input  logic signed [DataW-1:0]  value_i,
  output logic                     result_valid_o,
  output logic [1:0]               status_o,
  output logic [CountW-1:0]        count_o,
  output logic [IndexW-1:0]        element_index_o,
  output logic signed [DataW-1:0]  element_value_o,
  output logic                     last_o
);

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } state_e;

  state_e                  state_q;
  logic [CountW-1:0]       count_q;
  logic [IndexW-1:0]       idx_q;
  logic                    valid_q;
  status_e                 status_q;
  logic [IndexW-1:0]       index_q;
  logic signed [DataW-1:0] value_q;
  logic                    last_q;

  logic                    accept;
  logic                    ins_badpos, ins_full, del_badpos;
  logic                    trav_last;
  pai_ctrl_t               ctrl;

  // cell contents, one per slot
  logic signed [DataW-1:0] cell_data [CAPACITY];

  assign accept     = start_i && (state_q == S_IDLE);
  assign ins_badpos = position_i > count_q;
  assign ins_full   = count_q >= CountW'(CAPACITY);
  assign del_badpos = position_i >= count_q;
  // current head emission is the final one of the traverse
  assign trav_last  = ({1'b0, idx_q} + CountW'(1)) == count_q;

  // command for the whole chain this cycle
  always_comb begin
    ctrl.cmd = CMD_HOLD;
    ctrl.pos = position_i;
    ctrl.cnt = count_q;
    ctrl.val = value_i;
    if (state_q == S_TRAV) begin
      ctrl.cmd = CMD_ROTATE;
    end else if (accept) begin
      case (operation_i)
        OP_INSERT: if (!ins_badpos && !ins_full) ctrl.cmd = CMD_INSERT;
        OP_DELETE: if (!del_badpos) ctrl.cmd = CMD_DELETE;
        default:   ctrl.cmd = CMD_HOLD;
      endcase
    end
  end

  // row of cells, each linked to both neighbors and to the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    pai_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

  // control state, count and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
      status_q <= ST_OK;
      index_q <= '0;
      value_q <= '0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            valid_q  <= 1'b1;
            index_q  <= '0;
            value_q  <= '0;
            last_q   <= 1'b1;
            status_q <= ST_OK;
            case (operation_i)
              OP_INSERT: begin
                if (ins_badpos) begin
                  status_q <= ST_BADPOS;
                end else if (ins_full) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CountW'(1);
                end
              end
              OP_DELETE: begin
                if (del_badpos) begin
                  status_q <= ST_BADPOS;
                end else begin
                  count_q <= count_q - CountW'(1);
                end
              end
              OP_TRAVERSE: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                end else begin
                  // emissions start from the head once in S_TRAV
                  valid_q <= 1'b0;
                  idx_q   <= '0;
                  state_q <= S_TRAV;
                end
              end
              default: status_q <= ST_BADPOS;
            endcase
          end
        end
        S_TRAV: begin
          valid_q  <= 1'b1;
          status_q <= ST_OK;
          index_q  <= idx_q;
          value_q  <= cell_data[0];
          last_q   <= trav_last;
          idx_q    <= idx_q + IndexW'(1);
          if (trav_last) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = (state_q == S_TRAV);
  assign result_valid_o  = valid_q;
  assign status_o        = status_q;
  assign count_o         = count_q;
  assign element_index_o = index_q;
  assign element_value_o = value_q;
  assign last_o          = last_q;

endmodule

// ===== src/pai_cell.sv =====
// ----------------------------------------------------------------------------
// pai_cell
// one element slot of the chain; takes its own value, the inserted value, a neighbor or the head
// ----------------------------------------------------------------------------
module pai_cell import pai_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  pai_ctrl_t               ctrl_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  input  logic signed [DataW-1:0] head_i,
  output logic signed [DataW-1:0] data_o
);

  localparam logic [7:0] MyIdx   = 8'(IDX);
  localparam logic [7:0] NextIdx = 8'(IDX + 1);

  logic signed [DataW-1:0] data_q, data_d;
  logic [7:0]              pos_w, cnt_w;

  assign pos_w = {1'b0, ctrl_i.pos};
  assign cnt_w = {1'b0, ctrl_i.cnt};

  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (MyIdx == pos_w) begin
          data_d = ctrl_i.val;
        end else if (MyIdx > pos_w) begin
          data_d = left_i;
        end
      end
      CMD_DELETE: begin
        if (MyIdx >= pos_w) begin
          data_d = right_i;
        end
      end
      CMD_ROTATE: begin
        // held elements rotate toward the head, the head wraps to the tail
        if (NextIdx < cnt_w) begin
          data_d = right_i;
        end else if (NextIdx == cnt_w) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== src/pai_checker.sv =====
// ----------------------------------------------------------------------------
// pai_checker
// port level checks of the positional array, bound to the top level
// ----------------------------------------------------------------------------
module pai_checker import pai_pkg::*; #(
  parameter int CAPACITY = CapacityDef
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic [1:0]              operation_i,
  input logic                    result_valid_o,
  input logic [1:0]              status_o,
  input logic [CountW-1:0]       count_o,
  input logic [IndexW-1:0]       element_index_o,
  input logic signed [DataW-1:0] element_value_o,
  input logic                    last_o
);

  // single result items come in the cycle after accept and close the item
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i != OP_TRAVERSE) |=> (result_valid_o && last_o))
    else $error("single result item missing or not flagged last");

  // a traverse emission that is not last leaves the block busy
  a_trav_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("traverse stopped before its last item");

  // later traverse emissions follow the previous one with no gap
  a_trav_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && element_index_o != '0) |-> $past(result_valid_o))
    else $error("gap inside a traverse");

  // failed or empty results carry no element
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |->
      (element_index_o == '0 && element_value_o == '0 && last_o))
    else $error("error item carries element data");

  // the count never exceeds the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= CountW'(CAPACITY))
    else $error("count above capacity");

endmodule

bind positional_array_insert_delete pai_checker #(.CAPACITY(CAPACITY)) u_pai_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .count_o        (count_o),
  .element_index_o(element_index_o),
  .element_value_o(element_value_o),
  .last_o         (last_o)
);
